@@ rtl/core/erfs_pkg.sv @@
// Shared constants, register indexes, sequencer states and datapath types of the ellipse fit scorer.
package erfs_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int COORD_WIDTH_DEF = 32;

   localparam int SEMI_W     = 32;
   localparam int DIST_W     = 32;
   localparam int SUM_W      = 40;
   localparam int ACC_W      = 128;
   localparam int MUL_W      = 64;
   localparam int ROOT_W     = 64;
   localparam int REM_W      = 68;
   localparam int CNT_W      = 8;
   localparam int SQRT_STEPS = 64;
   localparam int DIV_STEPS  = 128;
   localparam int NORM_SHIFT = 31;
   localparam int CSR_IDX_W  = 3;

   localparam int SEMI_MAJOR_RST = 131072;
   localparam int SEMI_MINOR_RST = 65536;
   localparam int CENTRE_RST     = 65536;
   localparam int ANGLE_RST      = 46341;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEMI_MAJOR = 3'd0,
      CSR_SEMI_MINOR = 3'd1,
      CSR_CENTRE_X   = 3'd2,
      CSR_CENTRE_Y   = 3'd3,
      CSR_COS_ANGLE  = 3'd4,
      CSR_SIN_ANGLE  = 3'd5
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ROT_XA,
      S_ROT_XB,
      S_RND_XA,
      S_RND_XB,
      S_ROT_YA,
      S_ROT_YB,
      S_RND_YA,
      S_RND_YB,
      S_CHECK,
      S_NORM,
      S_MUL_AY,
      S_MUL_BX,
      S_MUL_AYSQ,
      S_MUL_BXSQ,
      S_SQRT_D,
      S_MUL_XS,
      S_MUL_YS,
      S_SQRT_RS,
      S_MUL_AB,
      S_MUL_ABRS,
      S_DIV_RE,
      S_MUL_XX,
      S_MUL_YY,
      S_SQRT_R,
      S_DIST_A,
      S_DIST_B,
      S_FINISH,
      S_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      UNIT_NONE,
      UNIT_MUL,
      UNIT_SQRT,
      UNIT_DIV
   } unit_type;

   typedef struct packed {
      logic [ACC_W-1:0] mcand;
      logic [MUL_W-1:0] mplier;
      logic             neg;
      logic             clr;
   } mul_setup_type;

endpackage

@@ rtl/core/erfs_req_if.sv @@
// Input channel carrying one sample point per transfer.
interface erfs_req_if import erfs_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
   logic                   valid;
   logic                   ready;
   logic [COORD_WIDTH-1:0] point_x;
   logic [COORD_WIDTH-1:0] point_y;
   logic                   last_point;

   modport source (output valid, output point_x, output point_y, output last_point,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input last_point,
                 output ready);
endinterface

@@ rtl/core/erfs_rsp_if.sv @@
// Result channel carrying one distance and running score per transfer.
interface erfs_rsp_if import erfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] point_distance;
   logic [SUM_W-1:0]  total_score;
   logic              at_centre;
   logic              set_done;

   modport source (output valid, output point_distance, output total_score,
                   output at_centre, output set_done, input ready);
   modport sink (input valid, input point_distance, input total_score,
                 input at_centre, input set_done, output ready);
endinterface

@@ rtl/core/ellipse_radial_fit_score_top.sv @@
// Ellipse radial fit scorer: distance of each point to a configured ellipse and a set score.
//
// A point is taken on req_chan when valid and ready are high together. Ready is high only
// while the block is idle; one point is worked on at a time. Each point yields exactly one
// result on rsp_chan, held stable until the receiver takes it; a stalled receiver keeps the
// block busy and req_chan not ready.
// The datapath is one 128-bit adder shared by a shift-and-add multiplier (one multiplier bit
// per cycle, stopping when the multiplier runs out of ones), a square root that retires two
// radicand bits per cycle over 64 steps, and a restoring divider of 128 steps.
// The time a point at the centre takes is set by the bit lengths of the cosine and sine. For
// any other point, the time from transfer in to result valid is set by the three square
// roots, the division (skipped when both products of a semi-axis and a coordinate are zero)
// and the bit lengths of the operands of fourteen multiplications.
// The csr port writes the semi-axes, the centre and the rotation cosine and sine; it is to be
// written only while the block is idle. The block itself does not enforce this.
// Synchronous reset returns the registers to their defaults, clears the running score and
// drops any point in progress. The score restarts at zero after a result marked set_done.
module ellipse_radial_fit_score_top import erfs_pkg::*; #(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   erfs_req_if.sink               req_chan,
   erfs_rsp_if.source             rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [((COORD_WIDTH > SEMI_W) ? COORD_WIDTH : SEMI_W)-1:0] csr_write_data
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int AW = FRAC_BITS + 2;
   localparam int XW = COORD_WIDTH + 3;

   state_type              state_ff, state_in;
   logic                   first_ff, first_in;

   logic [SEMI_W-1:0]      semi_major_ff, semi_major_in;
   logic [SEMI_W-1:0]      semi_minor_ff, semi_minor_in;
   logic [COORD_WIDTH-1:0] centre_x_ff, centre_x_in;
   logic [COORD_WIDTH-1:0] centre_y_ff, centre_y_in;
   logic [AW-1:0]          cos_ff, cos_in;
   logic [AW-1:0]          sin_ff, sin_in;
   logic [SUM_W-1:0]       score_ff, score_in;

   logic [DW-1:0]          dx_ff, dx_in;
   logic [DW-1:0]          dy_ff, dy_in;
   logic                   last_ff, last_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [ACC_W-1:0]       mcand_ff, mcand_in;
   logic [MUL_W-1:0]       mplier_ff, mplier_in;
   logic                   neg_ff, neg_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [XW-1:0]          x_mag_ff, x_mag_in;
   logic [XW-1:0]          y_mag_ff, y_mag_in;
   logic [XW-1:0]          xs_ff, xs_in;
   logic [XW-1:0]          ys_ff, ys_in;
   logic [MUL_W-1:0]       ay_ff, ay_in;
   logic [MUL_W-1:0]       bx_ff, bx_in;
   logic [ROOT_W-1:0]      d_ff, d_in;
   logic [SEMI_W-1:0]      rs_ff, rs_in;
   logic [MUL_W-1:0]       ab_ff, ab_in;
   logic [MUL_W-1:0]       re_ff, re_in;
   logic [ROOT_W-1:0]      r_ff, r_in;
   logic [DIST_W-1:0]      dist_ff, dist_in;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic                   centre_ff, centre_in;

   logic [DW-1:0]          dx_mag, dy_mag;
   logic [AW-1:0]          c_mag, s_mag;
   unit_type               unit;
   mul_setup_type          mul_op;
   logic [ACC_W-1:0]       add_a, add_b;
   logic                   add_sub;
   logic [ACC_W:0]         add_sum;
   logic                   add_carry;
   logic [REM_W-1:0]       sq_rem2;
   logic [MUL_W:0]         dv_rem2;
   logic                   mul_done, iter_done;
   logic [CNT_W-1:0]       iter_steps;
   logic                   norm_big, at_zero;
   logic [SEMI_W-1:0]      min_semi;
   logic [SUM_W:0]         total_sum;
   logic                   req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign dx_mag = dx_ff[DW-1] ? (~dx_ff + DW'(1)) : dx_ff;
   assign dy_mag = dy_ff[DW-1] ? (~dy_ff + DW'(1)) : dy_ff;
   assign c_mag  = cos_ff[AW-1] ? (~cos_ff + AW'(1)) : cos_ff;
   assign s_mag  = sin_ff[AW-1] ? (~sin_ff + AW'(1)) : sin_ff;

   assign sq_rem2   = {rem_ff[REM_W-3:0], acc_ff[ACC_W-1 -: 2]};
   assign dv_rem2   = {rem_ff[MUL_W-1:0], acc_ff[ACC_W-1]};
   assign add_sum   = {1'b0, add_a} + {1'b0, add_b ^ {ACC_W{add_sub}}}
                      + (ACC_W+1)'(add_sub);
   assign add_carry = add_sum[ACC_W];

   assign mul_done   = !first_ff && (mplier_ff == '0);
   assign iter_steps = (unit == UNIT_DIV) ? CNT_W'(DIV_STEPS) : CNT_W'(SQRT_STEPS);
   assign iter_done  = !first_ff && (cnt_ff == iter_steps);
   assign norm_big   = ((xs_ff >> NORM_SHIFT) != '0) || ((ys_ff >> NORM_SHIFT) != '0);
   assign at_zero    = (x_mag_ff == '0) && (y_mag_ff == '0);
   assign min_semi   = (semi_major_ff < semi_minor_ff) ? semi_major_ff : semi_minor_ff;
   assign total_sum  = {1'b0, score_ff} + (SUM_W+1)'(dist_ff);

   // Control decode: which unit runs, multiplier operands and the shared adder inputs.
   always_comb begin
      unit    = UNIT_NONE;
      mul_op  = '0;
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      req_chan.ready = (state_ff == S_IDLE);
      rsp_chan.valid = (state_ff == S_OUTPUT);
      case (state_ff)
         S_ROT_XA: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(dx_mag), mplier: MUL_W'(c_mag),
                       neg: cos_ff[AW-1] ^ dx_ff[DW-1], clr: 1'b1};
         end
         S_ROT_XB: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(dy_mag), mplier: MUL_W'(s_mag),
                       neg: sin_ff[AW-1] ^ dy_ff[DW-1], clr: 1'b0};
         end
         S_ROT_YA: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(dx_mag), mplier: MUL_W'(s_mag),
                       neg: ~sin_ff[AW-1] ^ dx_ff[DW-1], clr: 1'b1};
         end
         S_ROT_YB: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(dy_mag), mplier: MUL_W'(c_mag),
                       neg: cos_ff[AW-1] ^ dy_ff[DW-1], clr: 1'b0};
         end
         S_RND_XA, S_RND_YA: begin
            add_a = acc_ff;
            add_b = ACC_W'(1) << (FRAC_BITS - 1);
         end
         S_RND_XB, S_RND_YB: begin
            add_a = acc_ff[ACC_W-1] ? (~acc_ff >> FRAC_BITS) : (acc_ff >> FRAC_BITS);
            add_b = ACC_W'(acc_ff[ACC_W-1]);
         end
         S_MUL_AY: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(semi_major_ff), mplier: MUL_W'(ys_ff),
                       neg: 1'b0, clr: 1'b1};
         end
         S_MUL_BX: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(semi_minor_ff), mplier: MUL_W'(xs_ff),
                       neg: 1'b0, clr: 1'b1};
         end
         S_MUL_AYSQ: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(ay_ff), mplier: ay_ff, neg: 1'b0, clr: 1'b1};
         end
         S_MUL_BXSQ: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(bx_ff), mplier: bx_ff, neg: 1'b0, clr: 1'b0};
         end
         S_MUL_XS: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(xs_ff), mplier: MUL_W'(xs_ff), neg: 1'b0, clr: 1'b1};
         end
         S_MUL_YS: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(ys_ff), mplier: MUL_W'(ys_ff), neg: 1'b0, clr: 1'b0};
         end
         S_MUL_AB: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(semi_major_ff), mplier: MUL_W'(semi_minor_ff),
                       neg: 1'b0, clr: 1'b1};
         end
         S_MUL_ABRS: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(ab_ff), mplier: MUL_W'(rs_ff), neg: 1'b0, clr: 1'b1};
         end
         S_MUL_XX: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(x_mag_ff), mplier: MUL_W'(x_mag_ff),
                       neg: 1'b0, clr: 1'b1};
         end
         S_MUL_YY: begin
            unit   = UNIT_MUL;
            mul_op = '{mcand: ACC_W'(y_mag_ff), mplier: MUL_W'(y_mag_ff),
                       neg: 1'b0, clr: 1'b0};
         end
         S_SQRT_D, S_SQRT_RS, S_SQRT_R: begin
            unit = UNIT_SQRT;
         end
         S_DIV_RE: begin
            unit = UNIT_DIV;
         end
         S_DIST_A: begin
            add_a   = ACC_W'(r_ff);
            add_b   = ACC_W'(re_ff);
            add_sub = 1'b1;
         end
         S_DIST_B: begin
            add_a   = ACC_W'(re_ff);
            add_b   = ACC_W'(r_ff);
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
      case (unit)
         UNIT_MUL: begin
            add_a   = acc_ff;
            add_b   = mcand_ff;
            add_sub = neg_ff;
         end
         UNIT_SQRT: begin
            add_a   = ACC_W'(sq_rem2);
            add_b   = ACC_W'({root_ff, 2'b01});
            add_sub = 1'b1;
         end
         UNIT_DIV: begin
            add_a   = ACC_W'(dv_rem2);
            add_b   = ACC_W'(d_ff);
            add_sub = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_ROT_XA;
         S_ROT_XA:   if (mul_done) state_in = S_ROT_XB;
         S_ROT_XB:   if (mul_done) state_in = S_RND_XA;
         S_RND_XA:   state_in = S_RND_XB;
         S_RND_XB:   state_in = S_ROT_YA;
         S_ROT_YA:   if (mul_done) state_in = S_ROT_YB;
         S_ROT_YB:   if (mul_done) state_in = S_RND_YA;
         S_RND_YA:   state_in = S_RND_YB;
         S_RND_YB:   state_in = S_CHECK;
         S_CHECK:    state_in = at_zero ? S_FINISH : S_NORM;
         S_NORM:     if (!norm_big) state_in = S_MUL_AY;
         S_MUL_AY:   if (mul_done) state_in = S_MUL_BX;
         S_MUL_BX:   if (mul_done) state_in = S_MUL_AYSQ;
         S_MUL_AYSQ: if (mul_done) state_in = S_MUL_BXSQ;
         S_MUL_BXSQ: if (mul_done) state_in = S_SQRT_D;
         S_SQRT_D:   if (iter_done) state_in = S_MUL_XS;
         S_MUL_XS:   if (mul_done) state_in = S_MUL_YS;
         S_MUL_YS:   if (mul_done) state_in = S_SQRT_RS;
         S_SQRT_RS:  if (iter_done) state_in = S_MUL_AB;
         S_MUL_AB:   if (mul_done) state_in = S_MUL_ABRS;
         S_MUL_ABRS: if (mul_done) state_in = (d_ff == '0) ? S_MUL_XX : S_DIV_RE;
         S_DIV_RE:   if (iter_done) state_in = S_MUL_XX;
         S_MUL_XX:   if (mul_done) state_in = S_MUL_YY;
         S_MUL_YY:   if (mul_done) state_in = S_SQRT_R;
         S_SQRT_R:   if (iter_done) state_in = S_DIST_A;
         S_DIST_A:   state_in = add_carry ? S_FINISH : S_DIST_B;
         S_DIST_B:   state_in = S_FINISH;
         S_FINISH:   state_in = S_OUTPUT;
         S_OUTPUT:   if (rsp_fire) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   assign first_in = (state_in != state_ff);

   always_comb begin
      semi_major_in = semi_major_ff;
      semi_minor_in = semi_minor_ff;
      centre_x_in   = centre_x_ff;
      centre_y_in   = centre_y_ff;
      cos_in        = cos_ff;
      sin_in        = sin_ff;
      score_in      = score_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      last_in       = last_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      neg_in        = neg_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      cnt_in        = cnt_ff;
      x_mag_in      = x_mag_ff;
      y_mag_in      = y_mag_ff;
      xs_in         = xs_ff;
      ys_in         = ys_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      d_in          = d_ff;
      rs_in         = rs_ff;
      ab_in         = ab_ff;
      re_in         = re_ff;
      r_in          = r_ff;
      dist_in       = dist_ff;
      total_in      = total_ff;
      centre_in     = centre_ff;

      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SEMI_MAJOR: semi_major_in = csr_write_data[SEMI_W-1:0];
            CSR_SEMI_MINOR: semi_minor_in = csr_write_data[SEMI_W-1:0];
            CSR_CENTRE_X:   centre_x_in   = csr_write_data[COORD_WIDTH-1:0];
            CSR_CENTRE_Y:   centre_y_in   = csr_write_data[COORD_WIDTH-1:0];
            CSR_COS_ANGLE:  cos_in        = csr_write_data[AW-1:0];
            CSR_SIN_ANGLE:  sin_in        = csr_write_data[AW-1:0];
            default: begin
            end
         endcase
      end

      case (unit)
         UNIT_MUL: begin
            if (first_ff) begin
               mcand_in  = mul_op.mcand;
               mplier_in = mul_op.mplier;
               neg_in    = mul_op.neg;
               if (mul_op.clr) acc_in = '0;
            end else if (mplier_ff != '0) begin
               if (mplier_ff[0]) acc_in = add_sum[ACC_W-1:0];
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end
         UNIT_SQRT: begin
            if (first_ff) begin
               rem_in  = '0;
               root_in = '0;
               cnt_in  = '0;
            end else if (!iter_done) begin
               if (add_carry) begin
                  rem_in  = add_sum[REM_W-1:0];
                  root_in = {root_ff[ROOT_W-2:0], 1'b1};
               end else begin
                  rem_in  = sq_rem2;
                  root_in = {root_ff[ROOT_W-2:0], 1'b0};
               end
               acc_in = acc_ff << 2;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         UNIT_DIV: begin
            if (first_ff) begin
               rem_in = '0;
               cnt_in = '0;
            end else if (!iter_done) begin
               rem_in = add_carry ? add_sum[REM_W-1:0] : REM_W'(dv_rem2);
               acc_in = {acc_ff[ACC_W-2:0], add_carry};
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               dx_in   = {req_chan.point_x[COORD_WIDTH-1], req_chan.point_x}
                         - {centre_x_ff[COORD_WIDTH-1], centre_x_ff};
               dy_in   = {req_chan.point_y[COORD_WIDTH-1], req_chan.point_y}
                         - {centre_y_ff[COORD_WIDTH-1], centre_y_ff};
               last_in = req_chan.last_point;
            end
         end
         S_RND_XA, S_RND_YA: acc_in = add_sum[ACC_W-1:0];
         S_RND_XB: x_mag_in = add_sum[XW-1:0];
         S_RND_YB: y_mag_in = add_sum[XW-1:0];
         S_CHECK: begin
            centre_in = at_zero;
            if (at_zero) begin
               dist_in = min_semi;
            end else begin
               xs_in = x_mag_ff;
               ys_in = y_mag_ff;
            end
         end
         S_NORM: begin
            if (norm_big) begin
               xs_in = xs_ff >> 1;
               ys_in = ys_ff >> 1;
            end
         end
         S_MUL_AY:  if (mul_done) ay_in = acc_ff[MUL_W-1:0];
         S_MUL_BX:  if (mul_done) bx_in = acc_ff[MUL_W-1:0];
         S_SQRT_D:  if (iter_done) d_in = root_ff;
         S_SQRT_RS: if (iter_done) rs_in = root_ff[SEMI_W-1:0];
         S_MUL_AB:  if (mul_done) ab_in = acc_ff[MUL_W-1:0];
         S_MUL_ABRS: if (mul_done && (d_ff == '0)) re_in = '0;
         S_DIV_RE: begin
            if (iter_done) begin
               re_in = (acc_ff[ACC_W-1:MUL_W] != '0) ? '1 : acc_ff[MUL_W-1:0];
            end
         end
         S_SQRT_R: if (iter_done) r_in = root_ff;
         S_DIST_A: begin
            if (add_carry) begin
               dist_in = (add_sum[MUL_W-1:DIST_W] != '0) ? '1 : add_sum[DIST_W-1:0];
            end
         end
         S_DIST_B: begin
            dist_in = (add_sum[MUL_W-1:DIST_W] != '0) ? '1 : add_sum[DIST_W-1:0];
         end
         S_FINISH: total_in = total_sum[SUM_W] ? '1 : total_sum[SUM_W-1:0];
         S_OUTPUT: if (rsp_fire) score_in = last_ff ? '0 : total_ff;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_ff      <= 1'b0;
         score_ff      <= '0;
         semi_major_ff <= SEMI_W'(SEMI_MAJOR_RST);
         semi_minor_ff <= SEMI_W'(SEMI_MINOR_RST);
         centre_x_ff   <= COORD_WIDTH'(CENTRE_RST);
         centre_y_ff   <= COORD_WIDTH'(CENTRE_RST);
         cos_ff        <= AW'(ANGLE_RST);
         sin_ff        <= AW'(ANGLE_RST);
      end else begin
         state_ff      <= state_in;
         first_ff      <= first_in;
         score_ff      <= score_in;
         semi_major_ff <= semi_major_in;
         semi_minor_ff <= semi_minor_in;
         centre_x_ff   <= centre_x_in;
         centre_y_ff   <= centre_y_in;
         cos_ff        <= cos_in;
         sin_ff        <= sin_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      last_ff   <= last_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      neg_ff    <= neg_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      cnt_ff    <= cnt_in;
      x_mag_ff  <= x_mag_in;
      y_mag_ff  <= y_mag_in;
      xs_ff     <= xs_in;
      ys_ff     <= ys_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      d_ff      <= d_in;
      rs_ff     <= rs_in;
      ab_ff     <= ab_in;
      re_ff     <= re_in;
      r_ff      <= r_in;
      dist_ff   <= dist_in;
      total_ff  <= total_in;
      centre_ff <= centre_in;
   end

   assign rsp_chan.point_distance = dist_ff;
   assign rsp_chan.total_score    = total_ff;
   assign rsp_chan.at_centre      = centre_ff;
   assign rsp_chan.set_done       = last_ff;

   a_one_point_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("Input ready while a result is pending.");

   a_centre_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.at_centre |-> rsp_chan.point_distance == min_semi)
      else $error("Centre point does not report the smaller semi-axis.");

   a_score_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_chan.set_done |=> score_ff == '0)
      else $error("Running score not cleared after the end of a set.");

   a_total_covers_distance: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.total_score >= SUM_W'(rsp_chan.point_distance))
      else $error("Running score below the distance of this point.");

endmodule
